// ----- rtl/core/wfa_pkg.sv -----
// Shared constants for the worst-fit allocator.
// Field widths and command codes; no dependencies.
`timescale 1ns / 1ps

package wfa_pkg;

  // Port field widths
  localparam int CELL_FW = 13;
  localparam int REQ_FW  = 11;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

endpackage

// ----- rtl/core/wfa_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module wfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/worst_fit_allocator.sv -----
// Worst-fit cell allocator top level: sequencer, block and request tables.
// Depends on wfa_pkg and wfa_ram.
`timescale 1ns / 1ps

// Cells 1..total_cells start as one free block. An allocate beat walks the
// block list from cell 1, one block per cycle through the block-table read
// port, picks the largest free block (lowest start on ties), splits it when
// larger than the request and returns one result beat. A free beat merges
// with free neighbors and returns nothing. After reset or a total_cells
// write the tables are set up in S_INIT before the first beat is taken.
// Input is taken only while the sequencer is idle; a finished result waits
// in the output register.
module worst_fit_allocator
  import wfa_pkg::*;
#(
  parameter int MAX_CELLS    = 4096,
  parameter int MAX_REQUESTS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CELL_FW-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [CELL_FW-1:0] alloc_size,
  input  logic [REQ_FW-1:0]  free_request_number,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CELL_FW-1:0] start_cell,
  output logic               failed
);

  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int CA = $clog2(MAX_CELLS);
  localparam int RW = $clog2(MAX_REQUESTS + 2);
  localparam int RA = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int TOTAL_RST = (4096 > MAX_CELLS) ? MAX_CELLS : 4096;

  typedef struct packed {
    logic [CW-1:0] len;
    logic          free;
  } lf_t;

  typedef struct packed {
    logic          live;
    logic [CW-1:0] start;
  } rq_t;

  localparam logic [3:0] S_INIT    = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_DECIDE  = 4'd4;
  localparam logic [3:0] S_GRANT   = 4'd5;
  localparam logic [3:0] S_FAIL    = 4'd6;
  localparam logic [3:0] S_RESULT  = 4'd7;
  localparam logic [3:0] S_F0      = 4'd8;
  localparam logic [3:0] S_F1      = 4'd9;
  localparam logic [3:0] S_F2      = 4'd10;
  localparam logic [3:0] S_F3      = 4'd11;
  localparam logic [3:0] S_F4      = 4'd12;
  localparam logic [3:0] S_F5      = 4'd13;

  logic [3:0]         state;
  logic [RW-1:0]      counter;
  logic [CW-1:0]      total;
  logic [CW-1:0]      cur;
  logic [CW-1:0]      best;
  logic [CW-1:0]      best_len;
  logic [CELL_FW-1:0] size_r;
  logic               split;
  logic [RW-1:0]      req;
  logic [REQ_FW-1:0]  fnum;
  logic [CW-1:0]      s_r;
  logic [CW-1:0]      s_len;
  logic [CW-1:0]      p_r;
  logic [CW-1:0]      res_start;
  logic               res_fail;

  // Table ports
  logic          lf_we, p_we, rq_we;
  logic [CA-1:0] lf_waddr, p_waddr, t_raddr;
  lf_t           lf_wdata, lf_rdata;
  logic [CW-1:0] p_wdata, p_rdata;
  logic [RA-1:0] rq_waddr, rq_raddr;
  rq_t           rq_wdata, rq_rdata;

  // Working sums
  logic [CW:0]   scan_next;
  logic [CW:0]   split_end;
  logic [CW-1:0] rest;
  logic [CW:0]   s_end;
  logic [CW-1:0] merged_len;
  logic [CW:0]   merged_end;
  logic [CW-1:0] left_len;
  logic [CW:0]   left_end;
  logic          accept;
  logic [RW-1:0] counter_next;
  logic          req_ok;
  logic          fnum_ok;
  logic          fits;
  logic [CW-1:0] cfg_total;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  assign counter_next = (32'(counter) <= MAX_REQUESTS) ? counter + RW'(1) : counter;
  assign req_ok  = (32'(req) <= MAX_REQUESTS);
  assign fnum_ok = (fnum != '0) && (32'(fnum) <= MAX_REQUESTS) && (32'(fnum) < 32'(req));
  assign fits    = (best != '0) && (32'(best_len) >= 32'(size_r));

  assign scan_next  = {1'b0, cur} + {1'b0, lf_rdata.len};
  assign rest       = best + CW'(size_r);
  assign split_end  = {1'b0, best} + {1'b0, best_len};
  assign s_end      = {1'b0, s_r} + {1'b0, lf_rdata.len};
  assign merged_len = s_len + lf_rdata.len;
  assign merged_end = {1'b0, s_r} + {1'b0, merged_len};
  assign left_len   = lf_rdata.len + s_len;
  assign left_end   = {1'b0, p_r} + {1'b0, left_len};

  // Saturate the written cell count to 1..MAX_CELLS
  always_comb begin
    if (cfg_wr_data == '0) begin
      cfg_total = CW'(1);
    end else if (32'(cfg_wr_data) > MAX_CELLS) begin
      cfg_total = CW'(MAX_CELLS);
    end else begin
      cfg_total = CW'(cfg_wr_data);
    end
  end

  // Table read and write controls
  always_comb begin
    lf_we    = 1'b0;
    lf_waddr = '0;
    lf_wdata = '0;
    p_we     = 1'b0;
    p_waddr  = '0;
    p_wdata  = '0;
    rq_we    = 1'b0;
    rq_waddr = RA'(req - RW'(1));
    rq_wdata = '0;
    rq_raddr = RA'(fnum - REQ_FW'(1));
    t_raddr  = CA'(cur - CW'(1));
    unique case (state)
      S_INIT: begin
        lf_we    = 1'b1;
        lf_wdata = '{len: total, free: 1'b1};
        p_we     = 1'b1;
      end
      S_SCAN: begin
        t_raddr = CA'(scan_next - (CW + 1)'(1));
      end
      S_DECIDE: begin
        if (fits && (32'(best_len) > 32'(size_r))) begin
          lf_we    = 1'b1;
          lf_waddr = CA'(rest - CW'(1));
          lf_wdata = '{len: best_len - CW'(size_r), free: 1'b1};
          p_we     = 1'b1;
          p_waddr  = CA'(rest - CW'(1));
          p_wdata  = best;
        end
      end
      S_GRANT: begin
        lf_we    = 1'b1;
        lf_waddr = CA'(best - CW'(1));
        lf_wdata = '{len: CW'(size_r), free: 1'b0};
        if (split && (split_end <= {1'b0, total})) begin
          p_we    = 1'b1;
          p_waddr = CA'(split_end - (CW + 1)'(1));
          p_wdata = rest;
        end
        rq_we    = req_ok;
        rq_wdata = '{live: 1'b1, start: best};
      end
      S_FAIL: begin
        rq_we = req_ok;
      end
      S_F0: begin
        rq_we = req_ok;
      end
      S_F1: begin
        rq_we    = rq_rdata.live;
        rq_waddr = RA'(fnum - REQ_FW'(1));
        t_raddr  = CA'(rq_rdata.start - CW'(1));
      end
      S_F2: begin
        t_raddr = CA'(s_end - (CW + 1)'(1));
      end
      S_F3: begin
        if (lf_rdata.free && (merged_end <= {1'b0, total})) begin
          p_we    = 1'b1;
          p_waddr = CA'(merged_end - (CW + 1)'(1));
          p_wdata = s_r;
        end
      end
      S_F4: begin
        t_raddr = CA'(p_r - CW'(1));
        if (p_r == '0) begin
          lf_we    = 1'b1;
          lf_waddr = CA'(s_r - CW'(1));
          lf_wdata = '{len: s_len, free: 1'b1};
        end
      end
      S_F5: begin
        lf_we = 1'b1;
        if (lf_rdata.free) begin
          lf_waddr = CA'(p_r - CW'(1));
          lf_wdata = '{len: left_len, free: 1'b1};
          if (left_end <= {1'b0, total}) begin
            p_we    = 1'b1;
            p_waddr = CA'(left_end - (CW + 1)'(1));
            p_wdata = p_r;
          end
        end else begin
          lf_waddr = CA'(s_r - CW'(1));
          lf_wdata = '{len: s_len, free: 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      total     <= CW'(TOTAL_RST);
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        total <= cfg_total;
        state <= S_INIT;
      end else begin
        unique case (state)
          S_INIT: begin
            counter <= '0;
            state   <= S_IDLE;
          end
          S_IDLE: begin
            if (accept) begin
              counter <= counter_next;
              req     <= counter_next;
              size_r  <= alloc_size;
              fnum    <= free_request_number;
              cur     <= CW'(1);
              best    <= '0;
              best_len <= '0;
              if (command == CMD_FREE) begin
                state <= S_F0;
              end else if ((alloc_size == '0) || (32'(counter_next) > MAX_REQUESTS)) begin
                state <= S_FAIL;
              end else begin
                state <= S_SCAN_RD;
              end
            end
          end
          S_SCAN_RD: begin
            state <= S_SCAN;
          end
          S_SCAN: begin
            if (lf_rdata.free && (lf_rdata.len > best_len)) begin
              best     <= cur;
              best_len <= lf_rdata.len;
            end
            if ((lf_rdata.len == '0) || (scan_next > {1'b0, total})) begin
              state <= S_DECIDE;
            end else begin
              cur <= CW'(scan_next);
            end
          end
          S_DECIDE: begin
            split <= (32'(best_len) > 32'(size_r));
            state <= fits ? S_GRANT : S_FAIL;
          end
          S_GRANT: begin
            res_start <= best;
            res_fail  <= 1'b0;
            state     <= S_RESULT;
          end
          S_FAIL: begin
            res_start <= '0;
            res_fail  <= 1'b1;
            state     <= S_RESULT;
          end
          S_RESULT: begin
            if (!out_valid || !out_stall) begin
              out_valid  <= 1'b1;
              start_cell <= CELL_FW'(res_start);
              failed     <= res_fail;
              state      <= S_IDLE;
            end
          end
          S_F0: begin
            state <= fnum_ok ? S_F1 : S_IDLE;
          end
          S_F1: begin
            s_r   <= rq_rdata.start;
            state <= rq_rdata.live ? S_F2 : S_IDLE;
          end
          S_F2: begin
            s_len <= lf_rdata.len;
            p_r   <= p_rdata;
            if (lf_rdata.free) begin
              state <= S_IDLE;
            end else if (s_end <= {1'b0, total}) begin
              state <= S_F3;
            end else begin
              state <= S_F4;
            end
          end
          S_F3: begin
            if (lf_rdata.free) begin
              s_len <= merged_len;
            end
            state <= S_F4;
          end
          S_F4: begin
            state <= (p_r == '0) ? S_IDLE : S_F5;
          end
          S_F5: begin
            state <= S_IDLE;
          end
          default: begin
            state <= S_INIT;
          end
        endcase
      end
    end
  end

  // Block table: length and free flag per head cell
  wfa_ram #(.WIDTH(CW + 1), .DEPTH(MAX_CELLS), .AW(CA)) u_lf_ram (
    .clk   (clk),
    .we    (lf_we),
    .waddr (lf_waddr),
    .wdata (lf_wdata),
    .raddr (t_raddr),
    .rdata (lf_rdata)
  );

  // Block table: start of the previous block per head cell
  wfa_ram #(.WIDTH(CW), .DEPTH(MAX_CELLS), .AW(CA)) u_prev_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .raddr (t_raddr),
    .rdata (p_rdata)
  );

  // Request table: live flag and block start per request number
  wfa_ram #(.WIDTH(CW + 1), .DEPTH(MAX_REQUESTS), .AW(RA)) u_req_ram (
    .clk   (clk),
    .we    (rq_we),
    .waddr (rq_waddr),
    .wdata (rq_wdata),
    .raddr (rq_raddr),
    .rdata (rq_rdata)
  );

endmodule

// ----- tb/tb_worst_fit_allocator.sv -----
// Self-checking testbench for the worst-fit cell allocator.
// Depends on wfa_pkg and the worst_fit_allocator RTL; a model or a table row gives each result.
`timescale 1ns / 1ps

module tb_worst_fit_allocator
  import wfa_pkg::*;
();

  localparam int NCELLS     = 4096;
  localparam int NREQS      = 1024;
  localparam int CYC_LIMIT  = 1500000;
  localparam int SETTLE_CYC = 20;

  typedef struct {
    logic              cmd;
    logic [CELL_FW-1:0] size;
    logic [REQ_FW-1:0]  fnum;
    bit                 known;
    logic [CELL_FW-1:0] k_start;
    logic               k_failed;
  } stim_row_t;

  typedef struct {
    logic [CELL_FW-1:0] start;
    logic               failed;
  } grant_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [CELL_FW-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               command = CMD_ALLOC;
  logic [CELL_FW-1:0] alloc_size = '0;
  logic [REQ_FW-1:0]  free_request_number = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CELL_FW-1:0] start_cell;
  logic               failed;

  worst_fit_allocator u_top (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .alloc_size(alloc_size),
    .free_request_number(free_request_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .start_cell(start_cell), .failed(failed)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Allocator shadow state
  int unsigned cells_total;
  int unsigned req_count;
  int unsigned blk_len   [0:NCELLS];
  bit          blk_free  [0:NCELLS];
  bit          blk_head  [0:NCELLS];
  int unsigned blk_prev  [0:NCELLS];
  int unsigned req_start [0:NREQS];
  bit          req_live  [0:NREQS];
  int unsigned live_reqs [$];

  grant_t grants_due [$];
  int     fail_cnt = 0;
  int     cycles = 0;
  int     snd_pct = 0;
  int     rcv_pct = 0;

  function automatic void init_map(int unsigned n);
    req_count = 0;
    for (int i = 0; i <= NCELLS; i++) begin
      blk_len[i] = 0; blk_free[i] = 0; blk_head[i] = 0; blk_prev[i] = 0;
    end
    for (int i = 0; i <= NREQS; i++) begin
      req_start[i] = 0; req_live[i] = 0;
    end
    live_reqs.delete();
    cells_total = n;
    blk_len[1] = n; blk_free[1] = 1; blk_head[1] = 1;
  endfunction

  function automatic void link_next(int unsigned h);
    int unsigned nx;
    nx = h + blk_len[h];
    if (nx >= 1 && nx <= cells_total) blk_prev[nx] = h;
  endfunction

  function automatic void release_block(int unsigned r);
    int unsigned s, nx, p;
    if (r == 0 || r > NREQS || !req_live[r]) return;
    req_live[r] = 0;
    foreach (live_reqs[i]) if (live_reqs[i] == r) begin
      live_reqs.delete(i);
      break;
    end
    s = req_start[r];
    if (s == 0 || s > cells_total || !blk_head[s] || blk_free[s]) return;
    blk_free[s] = 1;
    // merge with the free block after
    nx = s + blk_len[s];
    if (nx <= cells_total && blk_head[nx] && blk_free[nx]) begin
      blk_len[s] += blk_len[nx];
      blk_head[nx] = 0; blk_free[nx] = 0; blk_len[nx] = 0; blk_prev[nx] = 0;
      link_next(s);
    end
    // merge into the free block before
    p = blk_prev[s];
    if (p != 0 && p <= cells_total && blk_head[p] && blk_free[p]) begin
      blk_len[p] += blk_len[s];
      blk_head[s] = 0; blk_free[s] = 0; blk_len[s] = 0; blk_prev[s] = 0;
      link_next(p);
    end
  endfunction

  function automatic int unsigned worst_fit(int unsigned size, int unsigned r);
    int unsigned c, best, best_len, len, rest;
    c = 1; best = 0; best_len = 0;
    if (size == 0 || r > NREQS) return 0;
    while (c <= cells_total) begin
      len = blk_len[c];
      if (len == 0) break;
      if (blk_free[c] && len > best_len) begin
        best = c; best_len = len;
      end
      c += len;
    end
    if (best == 0 || best_len < size) return 0;
    if (best_len > size) begin
      rest = best + size;
      blk_len[rest] = best_len - size;
      blk_free[rest] = 1; blk_head[rest] = 1; blk_prev[rest] = best;
      blk_len[best] = size;
      link_next(rest);
    end
    blk_free[best] = 0;
    req_start[r] = best;
    req_live[r] = 1;
    live_reqs.insert(live_reqs.size(), r);
    return best;
  endfunction

  // Advance the shadow state by one request; returns 1 when a result beat is due.
  function automatic bit predict_request(logic cmd, logic [CELL_FW-1:0] size,
                                         logic [REQ_FW-1:0] fnum, output grant_t g);
    int unsigned s;
    if (req_count <= NREQS) req_count++;
    if (cmd == CMD_FREE) begin
      release_block(32'(fnum));
      return 0;
    end
    s = worst_fit(32'(size), req_count);
    g.start = s[CELL_FW-1:0];
    g.failed = (s == 0);
    return 1;
  endfunction

  function automatic stim_row_t row(logic cmd, int size, int fnum, bit known = 0,
                                    int k_start = 0, bit k_failed = 0);
    stim_row_t r;
    r.cmd = cmd; r.size = CELL_FW'(size); r.fnum = REQ_FW'(fnum);
    r.known = known; r.k_start = CELL_FW'(k_start); r.k_failed = k_failed;
    return r;
  endfunction

  // Present one beat and hold it until accepted; valid stays high on return.
  task automatic send_beat(logic cmd, logic [CELL_FW-1:0] size, logic [REQ_FW-1:0] fnum,
                           bit known = 0, logic [CELL_FW-1:0] k_start = '0,
                           logic k_failed = 1'b0);
    grant_t g;
    bit due;
    while (($urandom % 100) < snd_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    alloc_size <= size;
    free_request_number <= fnum;
    do @(posedge clk); while (in_stall);
    due = predict_request(cmd, size, fnum, g);
    if (due) begin
      if (known) begin
        g.start = k_start;
        g.failed = k_failed;
      end
      grants_due.insert(grants_due.size(), g);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_cells(logic [CELL_FW-1:0] v);
    int unsigned n;
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    n = 32'(v);
    if (n < 1) n = 1;
    if (n > NCELLS) n = NCELLS;
    init_map(n);
  endtask

  // Mostly live frees and modest allocations, with some noise.
  task automatic random_phase(int n_items);
    int unsigned pick, sz, lim;
    lim = (cells_total / 4 > 1) ? cells_total / 4 : 1;
    repeat (n_items) begin
      pick = $urandom % 100;
      if (pick < 50)
        sz = $urandom_range(1, lim);
      else if (pick < 55)
        sz = $urandom_range(1, cells_total);
      else if (pick < 58)
        sz = ($urandom % 2) ? 0 : $urandom_range(cells_total, 8191);
      if (pick < 58)
        send_beat(CMD_ALLOC, CELL_FW'(sz), REQ_FW'($urandom_range(0, 2047)));
      else if (pick < 92 && live_reqs.size() != 0)
        send_beat(CMD_FREE, CELL_FW'($urandom),
                  REQ_FW'(live_reqs[$urandom % live_reqs.size()]));
      else
        send_beat(CMD_FREE, CELL_FW'($urandom), REQ_FW'($urandom_range(0, 2047)));
    end
  endtask

  // Receiver stall
  always @(posedge clk) out_stall <= (($urandom % 100) < rcv_pct);

  // Result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("FAIL worst_fit_allocator");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (grants_due.size() == 0) begin
        $error("unexpected result beat start_cell=%0d failed=%0d", start_cell, failed);
        fail_cnt++;
      end else begin
        if (start_cell !== grants_due[0].start) begin
          $error("start_cell expected %0d actual %0d", grants_due[0].start, start_cell);
          fail_cnt++;
        end
        if (failed !== grants_due[0].failed) begin
          $error("failed expected %0d actual %0d", grants_due[0].failed, failed);
          fail_cnt++;
        end
        void'(grants_due.pop_front());
      end
    end
  end

  initial begin
    stim_row_t tbl [$];
    init_map(NCELLS);
    // Directed: whole row, empty map, bad sizes, bad frees, merges both sides
    tbl.insert(tbl.size(), row(CMD_ALLOC, 4096, 0, 1, 1, 0));
    tbl.insert(tbl.size(), row(CMD_ALLOC, 1, 2047, 1, 0, 1));
    tbl.insert(tbl.size(), row(CMD_FREE, 8191, 1));
    tbl.insert(tbl.size(), row(CMD_ALLOC, 0, 0, 1, 0, 1));
    tbl.insert(tbl.size(), row(CMD_ALLOC, 8191, 0, 1, 0, 1));
    tbl.insert(tbl.size(), row(CMD_FREE, 0, 0));
    tbl.insert(tbl.size(), row(CMD_FREE, 0, 2047));
    tbl.insert(tbl.size(), row(CMD_FREE, 0, 1));
    tbl.insert(tbl.size(), row(CMD_FREE, 0, 2));
    tbl.insert(tbl.size(), row(CMD_ALLOC, 100, 0, 1, 1, 0));
    tbl.insert(tbl.size(), row(CMD_ALLOC, 200, 0, 1, 101, 0));
    tbl.insert(tbl.size(), row(CMD_ALLOC, 50, 0));
    tbl.insert(tbl.size(), row(CMD_FREE, 0, 10));
    tbl.insert(tbl.size(), row(CMD_FREE, 0, 12));
    tbl.insert(tbl.size(), row(CMD_ALLOC, 10, 0));
    tbl.insert(tbl.size(), row(CMD_FREE, 0, 11));
    tbl.insert(tbl.size(), row(CMD_ALLOC, 3786, 0));
    tbl.insert(tbl.size(), row(CMD_FREE, 0, 15));
    tbl.insert(tbl.size(), row(CMD_FREE, 0, 17));
    tbl.insert(tbl.size(), row(CMD_ALLOC, 4096, 1365, 1, 1, 0));

    snd_pct = 33; rcv_pct = 63;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (tbl[i])
      send_beat(tbl[i].cmd, tbl[i].size, tbl[i].fnum, tbl[i].known,
                tbl[i].k_start, tbl[i].k_failed);

    // Smallest map: zero saturates to one cell
    write_cells('0);
    random_phase(25);
    snd_pct = 63; rcv_pct = 33;
    write_cells(13'h1FFF);
    random_phase(40);
    snd_pct = 0; rcv_pct = 0;
    write_cells(CELL_FW'($urandom_range(2, 300)));
    random_phase(40);
    write_cells(CELL_FW'(4096));
    random_phase(15);

    drain();
    if (fail_cnt == 0)
      $display("PASS worst_fit_allocator");
    else
      $display("FAIL worst_fit_allocator");
    $finish;
  end

endmodule
